// File: sv/spi_nor_flash_command_sequencer_assert.svh
// Assertion macros shared by the checker file.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_ASSERT_SVH

// Checked at every rising edge outside reset.
`define SNFCS_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("snfcs assertion failed");

// Checked at every rising edge, reset included.
`define SNFCS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("snfcs assertion failed");

`endif

// File: sv/snfcs_pkg.sv
package snfcs_pkg;

    localparam logic [2:0] OP_JEDEC = 3'd0;
    localparam logic [2:0] OP_DEVID = 3'd1;
    localparam logic [2:0] OP_ERASE = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_WDATA = 3'd5;
    localparam logic [2:0] OP_RXB   = 3'd6;
    localparam logic [2:0] OP_RSVD  = 3'd7;

    localparam logic [2:0] K_XCHG  = 3'd0;
    localparam logic [2:0] K_REL   = 3'd1;
    localparam logic [2:0] K_REQ   = 3'd2;
    localparam logic [2:0] K_RDATA = 3'd3;
    localparam logic [2:0] K_ID    = 3'd4;
    localparam logic [2:0] K_DONE  = 3'd5;
    localparam logic [2:0] K_REJ   = 3'd6;

    // Flash instruction bytes, and the dummy byte shifted out while reading.
    localparam logic [7:0] FC_WREN  = 8'h06;
    localparam logic [7:0] FC_PP    = 8'h02;
    localparam logic [7:0] FC_RDSR  = 8'h05;
    localparam logic [7:0] FC_SE    = 8'h20;
    localparam logic [7:0] FC_READ  = 8'h03;
    localparam logic [7:0] FC_JEDEC = 8'h9F;
    localparam logic [7:0] FC_RDID  = 8'hAB;
    localparam logic [7:0] FC_DUMMY = 8'hFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [23:0] address;
        logic [24:0] length;
        logic [7:0]  write_byte;
        logic [7:0]  received_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tx_byte;
        logic [7:0]  read_data;
        logic [23:0] id_value;
        logic        last;
    } t_res;

    // Results caused by one input transfer: count 1 to 2, slot 0 first.
    typedef struct packed {
        logic [1:0]     cnt;
        t_res [2:0]     res;
    } t_grp;

endpackage

// File: sv/spi_nor_flash_command_sequencer.sv
// Path: a transfer's results are written to the result queue, then registered into o_data.
// Throughput: one input transfer per cycle while the two-entry result queue has room;
// results leave at one per cycle while i_ready accepts them.
// Reset: i_rst_n is synchronous and active low; it empties the queue and returns to idle.
module spi_nor_flash_command_sequencer #(
    parameter int PAGE_SIZE = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  snfcs_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output snfcs_pkg::t_res  o_data
);
    logic            w_push;
    snfcs_pkg::t_grp w_grp;

    snfcs_front #(.PAGE_SIZE(PAGE_SIZE)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_room  (o_ready),
        .o_push  (w_push),
        .o_grp   (w_grp)
    );

    snfcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_grp),
        .o_room  (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// File: sv/snfcs_front.sv
module snfcs_front #(
    parameter int PAGE_SIZE = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  snfcs_pkg::t_in   i_data,
    input  logic             i_room,
    output logic             o_push,
    output snfcs_pkg::t_grp  o_grp
);
    localparam int PB = $clog2(PAGE_SIZE);

    localparam logic [4:0] PH_IDLE          = 5'd0;
    localparam logic [4:0] PH_ID            = 5'd1;
    localparam logic [4:0] PH_WE            = 5'd2;
    localparam logic [4:0] PH_PRE_STAT_CMD  = 5'd3;
    localparam logic [4:0] PH_PRE_STAT      = 5'd4;
    localparam logic [4:0] PH_CMD           = 5'd5;
    localparam logic [4:0] PH_POST_STAT_CMD = 5'd6;
    localparam logic [4:0] PH_POST_STAT     = 5'd7;
    localparam logic [4:0] PH_WAIT_DATA     = 5'd8;
    localparam logic [4:0] PH_DATA          = 5'd9;
    localparam logic [4:0] PH_READ          = 5'd10;

    logic [4:0]  r_phase, n_phase;
    logic [2:0]  r_cmd, n_cmd;
    logic [23:0] r_addr, n_addr;
    logic [24:0] r_rem, n_rem;
    logic [PB:0] r_pbl, n_pbl;
    logic [2:0]  r_step, n_step;
    logic [23:0] r_acc, n_acc;

    typedef snfcs_pkg::t_grp t_grp_local;
    t_grp_local  w_grp;

    function automatic snfcs_pkg::t_res mk(input logic [2:0] k, input logic [7:0] tx,
                                           input logic [7:0] rd, input logic [23:0] id,
                                           input logic lst);
        snfcs_pkg::t_res r;
        r.kind = k; r.tx_byte = tx; r.read_data = rd; r.id_value = id; r.last = lst;
        return r;
    endfunction

    assign o_push = i_valid && i_room;
    assign o_grp  = w_grp;

    always_comb begin
        logic [1:0]    e;
        logic [PB:0]   room;
        logic [2:0]    stp;
        logic [PB:0]   pbl_d;
        logic [24:0]   rem_d;
        logic [23:0]   a_next;
        logic [23:0]   a_src;
        logic [24:0]   rem_src;
        logic          do_page;
        e = 2'd0;
        n_phase = r_phase; n_cmd = r_cmd; n_addr = r_addr; n_rem = r_rem;
        n_pbl = r_pbl; n_step = r_step; n_acc = r_acc;
        w_grp = '0;
        do_page = 1'b0;
        a_src = r_addr;
        rem_src = r_rem;
        stp = r_step + 3'd1;
        pbl_d = (r_pbl != '0) ? r_pbl - 1'b1 : r_pbl;
        rem_d = (r_rem != '0) ? r_rem - 25'd1 : r_rem;
        a_next = r_addr + 24'd1;
        if (i_data.opcode <= snfcs_pkg::OP_READ) begin
            if (r_phase != PH_IDLE) begin
                w_grp.res[e] = mk(snfcs_pkg::K_REJ, 8'h0, 8'h0, 24'h0, 1'b1); e = e + 2'd1;
            end else begin
                n_cmd = i_data.opcode; n_addr = i_data.address; n_rem = i_data.length;
                n_step = '0; n_acc = '0; n_pbl = '0;
                a_src = i_data.address; rem_src = i_data.length;
                unique case (i_data.opcode) inside
                    snfcs_pkg::OP_JEDEC, snfcs_pkg::OP_DEVID: begin
                        n_phase = PH_ID;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG,
                            (i_data.opcode == snfcs_pkg::OP_JEDEC) ? snfcs_pkg::FC_JEDEC
                                                                   : snfcs_pkg::FC_RDID,
                            8'h0, 24'h0, 1'b0); e = e + 2'd1;
                    end
                    snfcs_pkg::OP_ERASE: begin
                        n_phase = PH_WE;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_WREN, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end
                    snfcs_pkg::OP_WRITE: begin
                        if (i_data.length == '0) begin
                            n_phase = PH_IDLE;
                            w_grp.res[e] = mk(snfcs_pkg::K_DONE, 8'h0, 8'h0, 24'h0, 1'b1);
                            e = e + 2'd1;
                        end else begin
                            do_page = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_CMD;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_READ, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end
                endcase
            end
        end else if (i_data.opcode == snfcs_pkg::OP_WDATA) begin
            if (r_phase == PH_WAIT_DATA) begin
                n_phase = PH_DATA;
                w_grp.res[e] = mk(snfcs_pkg::K_XCHG, i_data.write_byte, 8'h0, 24'h0, 1'b0);
                e = e + 2'd1;
            end else begin
                w_grp.res[e] = mk(snfcs_pkg::K_REJ, 8'h0, 8'h0, 24'h0, 1'b1); e = e + 2'd1;
            end
        end else if (i_data.opcode == snfcs_pkg::OP_RXB) begin
            unique case (r_phase) inside
                PH_ID: begin
                    if (r_cmd == snfcs_pkg::OP_JEDEC) begin
                        if (r_step == 3'd1) n_acc = {i_data.received_byte, 16'h0};
                        else if (r_step == 3'd2) n_acc = r_acc | {8'h0, i_data.received_byte, 8'h0};
                        else if (r_step == 3'd3) n_acc = r_acc | {16'h0, i_data.received_byte};
                    end else if (r_step == 3'd4) begin
                        n_acc = {16'h0, i_data.received_byte};
                    end
                    if (r_step < ((r_cmd == snfcs_pkg::OP_JEDEC) ? 3'd3 : 3'd4)) begin
                        n_step = stp;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end else begin
                        n_phase = PH_IDLE;
                        w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                        w_grp.res[e] = mk(snfcs_pkg::K_ID, 8'h0, 8'h0, n_acc, 1'b1);
                        e = e + 2'd1;
                    end
                end
                PH_WE: begin
                    w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0); e = e + 2'd1;
                    if (r_cmd == snfcs_pkg::OP_ERASE) begin
                        n_phase = PH_PRE_STAT_CMD;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_RDSR, 8'h0,
                                          24'h0, 1'b0);
                    end else begin
                        n_phase = PH_CMD; n_step = '0;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_PP, 8'h0,
                                          24'h0, 1'b0);
                    end
                    e = e + 2'd1;
                end
                PH_PRE_STAT_CMD, PH_POST_STAT_CMD: begin
                    n_phase = (r_phase == PH_PRE_STAT_CMD) ? PH_PRE_STAT : PH_POST_STAT;
                    w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY, 8'h0,
                                      24'h0, 1'b0);
                    e = e + 2'd1;
                end
                PH_PRE_STAT: begin
                    if (i_data.received_byte[0]) begin
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end else begin
                        w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                        n_phase = PH_CMD; n_step = '0;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_SE, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end
                end
                PH_CMD: begin
                    if (r_step < 3'd3) begin
                        n_step = stp;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG,
                            (stp == 3'd1) ? r_addr[23:16] :
                            (stp == 3'd2) ? r_addr[15:8] : r_addr[7:0],
                            8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                    end else if (r_cmd == snfcs_pkg::OP_ERASE) begin
                        n_phase = PH_POST_STAT_CMD;
                        w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_RDSR, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end else if (r_cmd == snfcs_pkg::OP_WRITE) begin
                        n_phase = PH_WAIT_DATA;
                        w_grp.res[e] = mk(snfcs_pkg::K_REQ, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                    end else if (r_rem == '0) begin
                        n_phase = PH_IDLE;
                        w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                        w_grp.res[e] = mk(snfcs_pkg::K_DONE, 8'h0, 8'h0, 24'h0, 1'b1);
                        e = e + 2'd1;
                    end else begin
                        n_phase = PH_READ;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end
                end
                PH_POST_STAT: begin
                    if (i_data.received_byte[0]) begin
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end else begin
                        w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                        if (r_cmd == snfcs_pkg::OP_WRITE && r_rem != '0) begin
                            do_page = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                            w_grp.res[e] = mk(snfcs_pkg::K_DONE, 8'h0, 8'h0, 24'h0, 1'b1);
                            e = e + 2'd1;
                        end
                    end
                end
                PH_DATA: begin
                    n_pbl = pbl_d; n_rem = rem_d; n_addr = a_next;
                    if (pbl_d != '0) begin
                        n_phase = PH_WAIT_DATA;
                        w_grp.res[e] = mk(snfcs_pkg::K_REQ, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                    end else begin
                        n_phase = PH_POST_STAT_CMD;
                        w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_RDSR, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end
                end
                PH_READ: begin
                    n_rem = rem_d; n_addr = a_next;
                    if (rem_d != '0) begin
                        w_grp.res[e] = mk(snfcs_pkg::K_RDATA, 8'h0, i_data.received_byte,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                        w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY, 8'h0,
                                          24'h0, 1'b0);
                        e = e + 2'd1;
                    end else begin
                        n_phase = PH_IDLE;
                        w_grp.res[e] = mk(snfcs_pkg::K_REL, 8'h0, 8'h0, 24'h0, 1'b0);
                        e = e + 2'd1;
                        w_grp.res[e] = mk(snfcs_pkg::K_RDATA, 8'h0, i_data.received_byte,
                                          24'h0, 1'b1);
                        e = e + 2'd1;
                    end
                end
                default: begin
                    w_grp.res[e] = mk(snfcs_pkg::K_REJ, 8'h0, 8'h0, 24'h0, 1'b1);
                    e = e + 2'd1;
                end
            endcase
        end else begin
            w_grp.res[e] = mk(snfcs_pkg::K_REJ, 8'h0, 8'h0, 24'h0, 1'b1); e = e + 2'd1;
        end
        // A new page gets at most the room left before the next page boundary.
        room = (PB+1)'(PAGE_SIZE) - {1'b0, a_src[PB-1:0]};
        if (do_page) begin
            n_pbl = (rem_src < {{(25-PB-1){1'b0}}, room}) ? rem_src[PB:0] : room;
            n_phase = PH_WE;
            w_grp.res[e] = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_WREN, 8'h0, 24'h0, 1'b0);
            e = e + 2'd1;
        end
        w_grp.cnt = e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cmd   <= '0;
            r_addr  <= '0;
            r_rem   <= '0;
            r_pbl   <= '0;
            r_step  <= '0;
            r_acc   <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_addr  <= n_addr;
            r_rem   <= n_rem;
            r_pbl   <= n_pbl;
            r_step  <= n_step;
            r_acc   <= n_acc;
        end
    end

endmodule

// File: sv/snfcs_back.sv
module snfcs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  snfcs_pkg::t_grp  i_grp,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output snfcs_pkg::t_res  o_data
);
    snfcs_pkg::t_grp r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      r_idx;
    logic            r_valid;
    snfcs_pkg::t_res r_out;

    logic w_load, w_pop;
    snfcs_pkg::t_grp w_head;

    assign o_room  = (r_cnt != 2'd2);
    assign w_head  = r_q[r_rp];
    assign w_load  = (r_cnt != 2'd0) && (!r_valid || i_ready);
    assign w_pop   = w_load && (r_idx == w_head.cnt - 2'd1);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_grp;
        if (w_load) r_out <= w_head.res[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
            if (w_pop) r_idx <= '0;
            else if (w_load) r_idx <= r_idx + 2'd1;
            if (w_load) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

endmodule

// File: sv/snfcs_checker.sv
`include "spi_nor_flash_command_sequencer_assert.svh"

module snfcs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_valid,
    input logic            i_ready,
    input snfcs_pkg::t_res o_data
);
    `SNFCS_ASSERT_CLK(a_rej_last, i_clk, i_rst_n,
        o_valid && o_data.kind == snfcs_pkg::K_REJ |-> o_data.last)
    `SNFCS_ASSERT_CLK(a_xchg_not_last, i_clk, i_rst_n,
        o_valid && o_data.kind == snfcs_pkg::K_XCHG |-> !o_data.last && o_data.read_data == 8'h0)
    `SNFCS_ASSERT_CLK(a_hold, i_clk, i_rst_n,
        o_valid && !i_ready |=> o_valid && $stable(o_data))
    `SNFCS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)
endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int PAGE = 256;
    localparam int N_RANDOM_CMDS = 30;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID, PH_WE, PH_PRE_STAT_CMD, PH_PRE_STAT, PH_CMD,
        PH_POST_STAT_CMD, PH_POST_STAT, PH_WAIT_DATA, PH_DATA, PH_READ
    } t_phase;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    snfcs_pkg::t_in   i_data;
    logic             o_valid;
    logic             i_ready;
    snfcs_pkg::t_res  o_data;

    spi_nor_flash_command_sequencer #(.PAGE_SIZE(PAGE)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // Sequencer shadow state.
    t_phase      sh_phase;
    logic [2:0]  sh_cmd;
    logic [23:0] sh_addr;
    logic [24:0] sh_remaining;
    logic [8:0]  sh_page_left;
    logic [2:0]  sh_step;
    logic [23:0] sh_id;

    snfcs_pkg::t_res expected_results[$];
    int   n_errors;
    bit   quiet;

    function automatic snfcs_pkg::t_res mk(logic [2:0] k, logic [7:0] tx = 8'd0,
                                           logic [7:0] rd = 8'd0, logic [23:0] id = 24'd0,
                                           logic l = 1'b0);
        snfcs_pkg::t_res r;
        r.kind = k; r.tx_byte = tx; r.read_data = rd; r.id_value = id; r.last = l;
        return r;
    endfunction

    function automatic logic [7:0] addr_byte(logic [2:0] idx);
        if (idx == 3'd1) return sh_addr[23:16];
        if (idx == 3'd2) return sh_addr[15:8];
        return sh_addr[7:0];
    endfunction

    task automatic start_page();
        logic [24:0] room;
        room = 25'(PAGE) - 25'(sh_addr % 24'(PAGE));
        sh_page_left = (sh_remaining < room) ? sh_remaining[8:0] : room[8:0];
        sh_phase = PH_WE;
        expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_WREN));
    endtask

    task automatic finish_cmd();
        sh_phase = PH_IDLE;
        expected_results.push_back(mk(snfcs_pkg::K_DONE, .l(1'b1)));
    endtask

    task automatic predict_rx(logic [7:0] rx);
        logic [2:0] final_step;
        case (sh_phase)
            PH_ID: begin
                final_step = (sh_cmd == snfcs_pkg::OP_JEDEC) ? 3'd3 : 3'd4;
                if (sh_cmd == snfcs_pkg::OP_JEDEC) begin
                    if (sh_step == 3'd1) sh_id = {rx, 16'd0};
                    else if (sh_step == 3'd2) sh_id[15:8] = rx;
                    else if (sh_step == 3'd3) sh_id[7:0] = rx;
                end else if (sh_step == 3'd4) begin
                    sh_id = {16'd0, rx};
                end
                if (sh_step < final_step) begin
                    sh_step++;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY));
                end else begin
                    sh_phase = PH_IDLE;
                    expected_results.push_back(mk(snfcs_pkg::K_REL));
                    expected_results.push_back(mk(snfcs_pkg::K_ID, .id(sh_id), .l(1'b1)));
                end
            end
            PH_WE: begin
                expected_results.push_back(mk(snfcs_pkg::K_REL));
                if (sh_cmd == snfcs_pkg::OP_ERASE) begin
                    sh_phase = PH_PRE_STAT_CMD;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_RDSR));
                end else begin
                    sh_phase = PH_CMD;
                    sh_step = '0;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_PP));
                end
            end
            PH_PRE_STAT_CMD: begin
                sh_phase = PH_PRE_STAT;
                expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY));
            end
            PH_PRE_STAT: begin
                if (rx[0]) begin
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY));
                end else begin
                    expected_results.push_back(mk(snfcs_pkg::K_REL));
                    sh_phase = PH_CMD;
                    sh_step = '0;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_SE));
                end
            end
            PH_CMD: begin
                if (sh_step < 3'd3) begin
                    sh_step++;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, addr_byte(sh_step)));
                end else if (sh_cmd == snfcs_pkg::OP_ERASE) begin
                    sh_phase = PH_POST_STAT_CMD;
                    expected_results.push_back(mk(snfcs_pkg::K_REL));
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_RDSR));
                end else if (sh_cmd == snfcs_pkg::OP_WRITE) begin
                    sh_phase = PH_WAIT_DATA;
                    expected_results.push_back(mk(snfcs_pkg::K_REQ));
                end else if (sh_remaining == '0) begin
                    expected_results.push_back(mk(snfcs_pkg::K_REL));
                    finish_cmd();
                end else begin
                    sh_phase = PH_READ;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY));
                end
            end
            PH_POST_STAT_CMD: begin
                sh_phase = PH_POST_STAT;
                expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY));
            end
            PH_POST_STAT: begin
                if (rx[0]) begin
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY));
                end else begin
                    expected_results.push_back(mk(snfcs_pkg::K_REL));
                    if (sh_cmd == snfcs_pkg::OP_WRITE && sh_remaining != '0) start_page();
                    else finish_cmd();
                end
            end
            PH_DATA: begin
                if (sh_page_left != '0) sh_page_left--;
                if (sh_remaining != '0) sh_remaining--;
                sh_addr++;
                if (sh_page_left != '0) begin
                    sh_phase = PH_WAIT_DATA;
                    expected_results.push_back(mk(snfcs_pkg::K_REQ));
                end else begin
                    sh_phase = PH_POST_STAT_CMD;
                    expected_results.push_back(mk(snfcs_pkg::K_REL));
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_RDSR));
                end
            end
            PH_READ: begin
                if (sh_remaining != '0) sh_remaining--;
                sh_addr++;
                if (sh_remaining != '0) begin
                    expected_results.push_back(mk(snfcs_pkg::K_RDATA, .rd(rx)));
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_DUMMY));
                end else begin
                    sh_phase = PH_IDLE;
                    expected_results.push_back(mk(snfcs_pkg::K_REL));
                    expected_results.push_back(mk(snfcs_pkg::K_RDATA, .rd(rx), .l(1'b1)));
                end
            end
            default: expected_results.push_back(mk(snfcs_pkg::K_REJ, .l(1'b1)));
        endcase
    endtask

    task automatic predict_sequencer(snfcs_pkg::t_in it);
        if (it.opcode <= snfcs_pkg::OP_READ) begin
            if (sh_phase != PH_IDLE) begin
                expected_results.push_back(mk(snfcs_pkg::K_REJ, .l(1'b1)));
                return;
            end
            sh_cmd = it.opcode;
            sh_addr = it.address;
            sh_remaining = it.length;
            sh_step = '0;
            sh_id = '0;
            sh_page_left = '0;
            case (it.opcode)
                snfcs_pkg::OP_JEDEC, snfcs_pkg::OP_DEVID: begin
                    sh_phase = PH_ID;
                    expected_results.push_back(
                        mk(snfcs_pkg::K_XCHG, (it.opcode == snfcs_pkg::OP_JEDEC) ?
                           snfcs_pkg::FC_JEDEC : snfcs_pkg::FC_RDID));
                end
                snfcs_pkg::OP_ERASE: begin
                    sh_phase = PH_WE;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_WREN));
                end
                snfcs_pkg::OP_WRITE: begin
                    if (it.length == '0) finish_cmd();
                    else start_page();
                end
                default: begin
                    sh_phase = PH_CMD;
                    expected_results.push_back(mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_READ));
                end
            endcase
        end else if (it.opcode == snfcs_pkg::OP_WDATA) begin
            if (sh_phase == PH_WAIT_DATA) begin
                sh_phase = PH_DATA;
                expected_results.push_back(mk(snfcs_pkg::K_XCHG, it.write_byte));
            end else begin
                expected_results.push_back(mk(snfcs_pkg::K_REJ, .l(1'b1)));
            end
        end else if (it.opcode == snfcs_pkg::OP_RXB) begin
            predict_rx(it.received_byte);
        end else begin
            expected_results.push_back(mk(snfcs_pkg::K_REJ, .l(1'b1)));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Output side: comparison against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind=%0d", o_data.kind);
                    n_errors++;
                end else begin
                    snfcs_pkg::t_res e;
                    e = expected_results.pop_front();
                    if (o_data.kind !== e.kind) begin
                        $error("kind expected %0d actual %0d", e.kind, o_data.kind);
                        n_errors++;
                    end
                    if (o_data.tx_byte !== e.tx_byte) begin
                        $error("tx_byte expected %0h actual %0h", e.tx_byte, o_data.tx_byte);
                        n_errors++;
                    end
                    if (o_data.read_data !== e.read_data) begin
                        $error("read_data expected %0h actual %0h",
                               e.read_data, o_data.read_data);
                        n_errors++;
                    end
                    if (o_data.id_value !== e.id_value) begin
                        $error("id_value expected %0h actual %0h",
                               e.id_value, o_data.id_value);
                        n_errors++;
                    end
                    if (o_data.last !== e.last) begin
                        $error("last expected %0d actual %0d", e.last, o_data.last);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Output side: random stalls.
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (quiet) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left <= int'($urandom_range(1, 15)) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Sends one transfer, with an optional random gap before it.
    task automatic send(snfcs_pkg::t_in it);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_sequencer(it);
    endtask

    function automatic snfcs_pkg::t_in rnd_item(logic [2:0] op);
        snfcs_pkg::t_in it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(snfcs_pkg::t_in)-1:0];
        it.opcode = op;
        return it;
    endfunction

    // Answers exchanges and data requests as the sequencer asks, until idle.
    task automatic drive_to_idle(int busy_polls);
        snfcs_pkg::t_in it;
        int polls;
        polls = busy_polls;
        while (sh_phase != PH_IDLE) begin
            if (sh_phase == PH_WAIT_DATA) begin
                it = rnd_item(snfcs_pkg::OP_WDATA);
            end else begin
                it = rnd_item(snfcs_pkg::OP_RXB);
                if (sh_phase == PH_PRE_STAT || sh_phase == PH_POST_STAT) begin
                    it.received_byte[0] = (polls > 0);
                    if (polls > 0) polls--;
                end
            end
            // Occasional stray or busy noise mid-sequence.
            if ($urandom_range(0, 19) == 0) send(rnd_item(3'($urandom_range(0, 7))));
            if (sh_phase == PH_WAIT_DATA && it.opcode == snfcs_pkg::OP_RXB) continue;
            send(it);
        end
    endtask

    task automatic run_cmd(logic [2:0] op, logic [23:0] a, logic [24:0] len);
        snfcs_pkg::t_in it;
        it = rnd_item(op);
        it.address = a;
        it.length = len;
        send(it);
        drive_to_idle($urandom_range(0, 3));
    endtask

    // Directed single items whose results are read off directly from idle.
    typedef struct {
        snfcs_pkg::t_in  item;
        snfcs_pkg::t_res want;
    } t_row;

    t_row rows[6];

    initial begin
        snfcs_pkg::t_in it;
        n_errors = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        sh_phase = PH_IDLE;
        sh_cmd = '0; sh_addr = '0; sh_remaining = '0; sh_page_left = '0;
        sh_step = '0; sh_id = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows[0].item = '1;              rows[0].item.opcode = snfcs_pkg::OP_WDATA;
        rows[1].item = '1;              rows[1].item.opcode = snfcs_pkg::OP_RXB;
        rows[2].item = '1;              rows[2].item.opcode = snfcs_pkg::OP_RSVD;
        rows[3].item = '0;              rows[3].item.opcode = snfcs_pkg::OP_WRITE;
        rows[4].item = '0;              rows[4].item.opcode = snfcs_pkg::OP_JEDEC;
        rows[5].item = '0;              rows[5].item.opcode = snfcs_pkg::OP_READ;
        for (int i = 0; i < 3; i++) rows[i].want = mk(snfcs_pkg::K_REJ, .l(1'b1));
        rows[3].want = mk(snfcs_pkg::K_DONE, .l(1'b1));
        rows[4].want = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_JEDEC);
        rows[5].want = mk(snfcs_pkg::K_XCHG, snfcs_pkg::FC_READ);
        foreach (rows[i]) begin
            send(rows[i].item);
            if (expected_results[$] !== rows[i].want) begin
                $error("directed row %0d prediction expected %p actual %p",
                       i, rows[i].want, expected_results[$]);
                n_errors++;
            end
            // A command while busy is rejected.
            if (i == 4) send(rnd_item(snfcs_pkg::OP_ERASE));
            if (i >= 4) drive_to_idle(0);
        end
        // Device id, erase at the top address, empty read, page-crossing writes, wrap.
        run_cmd(snfcs_pkg::OP_DEVID, 24'h0, 25'h0);
        run_cmd(snfcs_pkg::OP_ERASE, 24'hFFFFFF, 25'h0);
        run_cmd(snfcs_pkg::OP_READ, 24'h123456, 25'h0);
        run_cmd(snfcs_pkg::OP_WRITE, 24'hFFFFFE, 25'd4);
        run_cmd(snfcs_pkg::OP_WRITE, 24'h0000FD, 25'd3);
        run_cmd(snfcs_pkg::OP_READ, 24'hFFFFFF, 25'd2);

        for (int n = 0; n < N_RANDOM_CMDS; n++) begin
            if (n == N_RANDOM_CMDS - 10) quiet = 1'b1;
            case ($urandom_range(0, 5))
                0: run_cmd(snfcs_pkg::OP_JEDEC, 24'($urandom), 25'($urandom));
                1: run_cmd(snfcs_pkg::OP_DEVID, 24'($urandom), 25'($urandom));
                2: run_cmd(snfcs_pkg::OP_ERASE, 24'($urandom), 25'($urandom));
                3: run_cmd(snfcs_pkg::OP_WRITE, 24'($urandom) | 24'hF0,
                           ($urandom_range(0, 9) == 0) ? 25'd0 : 25'($urandom_range(1, 12)));
                4: run_cmd(snfcs_pkg::OP_READ, 24'($urandom),
                           ($urandom_range(0, 9) == 0) ? 25'd0 : 25'($urandom_range(1, 6)));
                default: send(rnd_item(3'($urandom_range(5, 7))));
            endcase
        end
        // Large lengths: start, then show the sequencer stays busy and reads on.
        it = rnd_item(snfcs_pkg::OP_READ);
        it.length = 25'h1FFFFFF;
        send(it);
        repeat (6) send(rnd_item(snfcs_pkg::OP_RXB));
        send(rnd_item(snfcs_pkg::OP_JEDEC));
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
